// ===== src/bpi_pkg.sv =====
// Shared types and constant curve tables for the battery percent interpolator.
`default_nettype none

package bpi_pkg;

    // Curve geometry: both curves are held as ten points; the unloaded curve is
    // padded by repeating its last point, which never wins the segment search.
    localparam int NPTS   = 10;
    localparam int SEG_W  = 4;
    localparam int OFF_W  = 10;   // offset inside a segment, below 600
    localparam int DP_W   = 5;    // percent span of a segment, up to 25
    localparam int HDV_W  = 9;    // half the voltage span, up to 300
    localparam int RCP_W  = 17;   // ceil(2^24 / span)
    localparam int NUM_W  = 14;   // off * dp + span / 2, below 15300
    localparam int PRD_W  = NUM_W + RCP_W;
    localparam int RCP_SH = 24;
    localparam int PCT_W  = 7;
    localparam int VU_W   = 8;

    // Voltage units: (mv + 50) / 100 via reciprocal multiply, exact below 25500
    localparam logic [16:0] VOLT_HALF  = 17'd50;
    localparam logic [16:0] VOLT_SAT_X = 17'd25500;
    localparam logic [12:0] VOLT_RCP   = 13'd5243;
    localparam int          VOLT_SH    = 19;
    localparam logic [VU_W-1:0] VOLT_SAT = 8'hFE;

    // Curve select codes
    localparam logic MODE_LOADED   = 1'b0;
    localparam logic MODE_UNLOADED = 1'b1;

    // Point voltages in mV, highest first
    localparam logic [15:0] CURVE_MV [2][NPTS] = '{
        '{16'd6400, 16'd6000, 16'd5800, 16'd5600, 16'd5400,
          16'd5200, 16'd5000, 16'd4700, 16'd4400, 16'd4000},
        '{16'd7000, 16'd6400, 16'd6100, 16'd5900, 16'd5700,
          16'd5400, 16'd5000, 16'd4400, 16'd4400, 16'd4400}
    };

    // Point percents
    localparam logic [PCT_W-1:0] CURVE_PCT [2][NPTS] = '{
        '{7'd100, 7'd95, 7'd85, 7'd70, 7'd55, 7'd40, 7'd25, 7'd10, 7'd3, 7'd0},
        '{7'd100, 7'd90, 7'd70, 7'd45, 7'd25, 7'd10, 7'd3, 7'd0, 7'd0, 7'd0}
    };

    // Reciprocal of the span of the segment that ends at point k
    localparam logic [RCP_W-1:0] CURVE_RCP [2][NPTS] = '{
        '{17'd0, 17'd41944, 17'd83887, 17'd83887, 17'd83887,
          17'd83887, 17'd83887, 17'd55925, 17'd55925, 17'd41944},
        '{17'd0, 17'd27963, 17'd55925, 17'd83887, 17'd83887,
          17'd55925, 17'd41944, 17'd27963, 17'd0, 17'd0}
    };

    // Segment description handed from the search to the arithmetic stages
    typedef struct packed {
        logic             clamp;
        logic [PCT_W-1:0] clamp_pct;
        logic [OFF_W-1:0] off;
        logic [DP_W-1:0]  dp;
        logic [HDV_W-1:0] half_dv;
        logic [RCP_W-1:0] rcp;
        logic [PCT_W-1:0] bot_p;
    } t_seg;

endpackage

`default_nettype wire

// ===== src/bpi_in_if.sv =====
// Input channel: pack voltage and curve select with valid/ready.
`default_nettype none

interface bpi_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pack_mv;
    logic        mode;

    modport source (output valid, output pack_mv, output mode, input ready);
    modport sink   (input valid, input pack_mv, input mode, output ready);
endinterface

`default_nettype wire

// ===== src/bpi_out_if.sv =====
// Output channel: percent and voltage units with valid/ready.
`default_nettype none

interface bpi_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] percent;
    logic [7:0] voltage_units;

    modport source (output valid, output percent, output voltage_units, input ready);
    modport sink   (input valid, input percent, input voltage_units, output ready);
endinterface

`default_nettype wire

// ===== src/bpi_seg_find.sv =====
// Segment search: clamps at the curve ends or picks the enclosing segment.
`default_nettype none

module bpi_seg_find (
    input  wire logic [15:0] i_mv,
    input  wire logic        i_mode,
    output bpi_pkg::t_seg    o_seg
);

    logic [bpi_pkg::SEG_W-1:0] seg;
    logic [15:0]               top_mv;
    logic [15:0]               bot_mv;
    logic [15:0]               dv;
    logic [15:0]               off;
    logic [bpi_pkg::PCT_W-1:0] top_p;
    logic [bpi_pkg::PCT_W-1:0] bot_p;
    logic [bpi_pkg::PCT_W-1:0] dp;

    // First point at or below the voltage among points 1 to NPTS-1, all searched at once
    always_comb begin
        seg = bpi_pkg::SEG_W'(bpi_pkg::NPTS - 1);
        for (int k = bpi_pkg::NPTS - 1; k >= 1; k--) begin
            if (i_mv >= bpi_pkg::CURVE_MV[i_mode][k]) begin
                seg = bpi_pkg::SEG_W'(k);
            end
        end
    end

    // Segment endpoints and spans
    always_comb begin
        top_mv = bpi_pkg::CURVE_MV[i_mode][seg - 1'b1];
        bot_mv = bpi_pkg::CURVE_MV[i_mode][seg];
        top_p  = bpi_pkg::CURVE_PCT[i_mode][seg - 1'b1];
        bot_p  = bpi_pkg::CURVE_PCT[i_mode][seg];
        dv     = top_mv - bot_mv;
        off    = i_mv - bot_mv;
        dp     = top_p - bot_p;
    end

    // Clamp at or above the first point and at or below the last point
    always_comb begin
        o_seg.clamp     = 1'b0;
        o_seg.clamp_pct = bpi_pkg::CURVE_PCT[i_mode][0];
        if (i_mv >= bpi_pkg::CURVE_MV[i_mode][0]) begin
            o_seg.clamp = 1'b1;
        end else if (i_mv <= bpi_pkg::CURVE_MV[i_mode][bpi_pkg::NPTS-1]) begin
            o_seg.clamp     = 1'b1;
            o_seg.clamp_pct = bpi_pkg::CURVE_PCT[i_mode][bpi_pkg::NPTS-1];
        end
        o_seg.off     = off[bpi_pkg::OFF_W-1:0];
        o_seg.dp      = dp[bpi_pkg::DP_W-1:0];
        o_seg.half_dv = dv[bpi_pkg::HDV_W:1];
        o_seg.rcp     = bpi_pkg::CURVE_RCP[i_mode][seg];
        o_seg.bot_p   = bot_p;
    end

endmodule

`default_nettype wire

// ===== src/battery_percent_interpolator_core.sv =====
// Top level: four-stage pipeline from pack voltage to percent and voltage units.
//
//   channel  dir  payload                      transfer when
//   i_in     in   pack_mv[15:0], mode          valid && ready
//   o_res    out  percent[6:0], voltage_units  valid && ready
//
// One item per cycle enters while the output register is not stalled; each
// result passes through the stages search, numerator, reciprocal multiply and
// add/select. The 14x17 reciprocal multiply replaces the segment divide.
// A stalled output register holds the whole pipeline; ready is low only then.
// Reset (synchronous, active low) clears the stage valid bits.
`default_nettype none

module battery_percent_interpolator_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpi_in_if.sink     i_in,
    bpi_out_if.source  o_res
);

    logic advance;

    // Stage 1: segment and voltage product
    bpi_pkg::t_seg                 seg;
    bpi_pkg::t_seg                 r_seg1;
    logic                          r_v1;
    logic                          r_sat1;
    logic [27:0]                   r_vprd1;
    logic [16:0]                   vx;

    // Stage 2: numerator
    logic                          r_v2;
    logic [bpi_pkg::NUM_W-1:0]     r_num2;
    logic [bpi_pkg::RCP_W-1:0]     r_rcp2;
    logic [bpi_pkg::PCT_W-1:0]     r_bot2;
    logic                          r_clamp2;
    logic [bpi_pkg::PCT_W-1:0]     r_cpct2;
    logic [bpi_pkg::VU_W-1:0]      r_vu2;
    logic [bpi_pkg::NUM_W-1:0]     n_num2;

    // Stage 3: reciprocal product
    logic                          r_v3;
    logic [bpi_pkg::PRD_W-1:0]     r_prd3;
    logic [bpi_pkg::PCT_W-1:0]     r_bot3;
    logic                          r_clamp3;
    logic [bpi_pkg::PCT_W-1:0]     r_cpct3;
    logic [bpi_pkg::VU_W-1:0]      r_vu3;

    // Stage 4: output register
    logic                          r_v4;
    logic [bpi_pkg::PCT_W-1:0]     r_pct4;
    logic [bpi_pkg::VU_W-1:0]      r_vu4;
    logic [bpi_pkg::PCT_W-1:0]     n_pct4;

    // Whole pipeline moves unless the output holds an untaken result
    assign advance    = !r_v4 || o_res.ready;
    assign i_in.ready = advance;

    bpi_seg_find u_seg_find (
        .i_mv   (i_in.pack_mv),
        .i_mode (i_in.mode),
        .o_seg  (seg)
    );

    assign vx = {1'b0, i_in.pack_mv} + bpi_pkg::VOLT_HALF;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Numerator and final select
    assign n_num2 = bpi_pkg::NUM_W'(r_seg1.off) * bpi_pkg::NUM_W'(r_seg1.dp)
                  + bpi_pkg::NUM_W'(r_seg1.half_dv);
    assign n_pct4 = r_clamp3 ? r_cpct3
                             : r_bot3 + r_prd3[bpi_pkg::RCP_SH +: bpi_pkg::PCT_W];

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_seg1   <= seg;
            r_sat1   <= vx >= bpi_pkg::VOLT_SAT_X;
            r_vprd1  <= 28'(vx[14:0]) * 28'(bpi_pkg::VOLT_RCP);

            r_num2   <= n_num2;
            r_rcp2   <= r_seg1.rcp;
            r_bot2   <= r_seg1.bot_p;
            r_clamp2 <= r_seg1.clamp;
            r_cpct2  <= r_seg1.clamp_pct;
            r_vu2    <= r_sat1 ? bpi_pkg::VOLT_SAT
                               : r_vprd1[bpi_pkg::VOLT_SH +: bpi_pkg::VU_W];

            r_prd3   <= bpi_pkg::PRD_W'(r_num2) * bpi_pkg::PRD_W'(r_rcp2);
            r_bot3   <= r_bot2;
            r_clamp3 <= r_clamp2;
            r_cpct3  <= r_cpct2;
            r_vu3    <= r_vu2;

            r_pct4   <= n_pct4;
            r_vu4    <= r_vu3;
        end
    end

    assign o_res.valid         = r_v4;
    assign o_res.percent       = r_pct4;
    assign o_res.voltage_units = r_vu4;

endmodule

`default_nettype wire
